// ===== rtl/core/msprank_pkg.sv =====
// types, constants and helper functions for the multiset permutation rank unit
// no dependencies; imported by multiset_permutation_rank_unit
package msprank_pkg;

  localparam int MAX_POS = 8;   // largest arrangement length
  localparam int DIGIT_W = 4;
  localparam int RANK_W  = 16;
  localparam int SM_W    = 3;   // count of smaller later digits, 0..7
  localparam int CNT_W   = 4;   // occurrences of a digit in a suffix, 1..8
  localparam int SH_W    = 2;   // power-of-two part of a count, 0..3

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [SM_W-1:0]    sm_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SH_W-1:0]    sh_t;

  // inverses of the odd count parts modulo 2^16
  localparam rank_t INV_1 = 16'h0001;
  localparam rank_t INV_3 = 16'hAAAB;
  localparam rank_t INV_5 = 16'hCCCD;
  localparam rank_t INV_7 = 16'h6DB7;

  // per-position data carried down the chain
  typedef struct packed {
    sm_t  [MAX_POS-1:0] sm;
    cnt_t [MAX_POS-1:0] cnt;
  } pos_info_t;

  // shift that strips the power of two out of a count
  function automatic sh_t div_shift(input cnt_t c);
    sh_t s;
    case (c)
      4'd2, 4'd6: s = 2'd1;
      4'd4:       s = 2'd2;
      4'd8:       s = 2'd3;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

  // modular inverse of the odd part of a count
  function automatic rank_t div_inv(input cnt_t c);
    rank_t v;
    case (c)
      4'd3, 4'd6: v = INV_3;
      4'd5:       v = INV_5;
      4'd7:       v = INV_7;
      default:    v = INV_1;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/multiset_permutation_rank_unit.sv =====
// throughput: one transaction per cycle; busy is high only while rst_n is low
// path from start to out_valid: capture stage, count stage, then one two-register step
// per digit position, each with two 16x16 multipliers
// rank built right to left: term = perms(suffix) * smaller / count, exact division
// rst_n synchronous active low clears all valid bits; payload registers are not reset
// depends on msprank_pkg
module multiset_permutation_rank_unit
  import msprank_pkg::*;
#(
  parameter int NUM_DIGITS = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  digit_t in_digit_0,
  input  digit_t in_digit_1,
  input  digit_t in_digit_2,
  input  digit_t in_digit_3,
  input  digit_t in_digit_4,
  input  digit_t in_digit_5,
  input  digit_t in_digit_6,
  input  digit_t in_digit_7,
  output logic   out_valid,
  output rank_t  out_rank
);

  localparam int LAT = 2 * NUM_DIGITS + 2;

  // never stalls outside reset
  assign busy = !rst_n;

  digit_t in_dig [MAX_POS];
  assign in_dig[0] = in_digit_0;
  assign in_dig[1] = in_digit_1;
  assign in_dig[2] = in_digit_2;
  assign in_dig[3] = in_digit_3;
  assign in_dig[4] = in_digit_4;
  assign in_dig[5] = in_digit_5;
  assign in_dig[6] = in_digit_6;
  assign in_dig[7] = in_digit_7;

  // stage 0: capture the transaction
  logic   v0_r;
  digit_t dig_r [NUM_DIGITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig_r[i] <= in_dig[i];
    end
  end

  // stage 1: smaller later digits and suffix occurrences per position
  logic      v1_r;
  pos_info_t info1_r;
  pos_info_t info1_nxt;

  always_comb begin
    info1_nxt = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
        if (j > i && dig_r[j] < dig_r[i]) begin
          info1_nxt.sm[i] = info1_nxt.sm[i] + SM_W'(1);
        end
        if (j >= i && dig_r[j] == dig_r[i]) begin
          info1_nxt.cnt[i] = info1_nxt.cnt[i] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    info1_r <= info1_nxt;
  end

  // chain links between position steps
  logic      ch_v    [NUM_DIGITS+1];
  rank_t     ch_p    [NUM_DIGITS+1];
  rank_t     ch_tot  [NUM_DIGITS+1];
  pos_info_t ch_info [NUM_DIGITS+1];

  assign ch_v[0]    = v1_r;
  assign ch_p[0]    = rank_t'(1);
  assign ch_tot[0]  = '0;
  assign ch_info[0] = info1_r;

  // one step per position, last position first
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_step
    localparam int POS = NUM_DIGITS - 1 - k;
    localparam int M   = k + 1;   // suffix length at this position

    logic                va_r;
    rank_t               xt_r;
    rank_t               xp_r;
    sh_t                 sh_r;
    rank_t               inv_r;
    rank_t               tota_r;
    pos_info_t           infoa_r;
    logic [RANK_W+2:0]   xt_full;
    logic [RANK_W+3:0]   xp_full;

    logic                vb_r;
    rank_t               pb_r;
    rank_t               totb_r;
    pos_info_t           infob_r;
    logic [2*RANK_W-1:0] mt_full;
    logic [2*RANK_W-1:0] mp_full;
    rank_t               term;

    // sub-step a: scale suffix perms by smaller count and by length
    assign xt_full = {3'b0, ch_p[k]} * {{RANK_W{1'b0}}, ch_info[k].sm[POS]};
    assign xp_full = {4'b0, ch_p[k]} * (RANK_W+4)'(M);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r <= 1'b0;
      end else begin
        va_r <= ch_v[k];
      end
    end

    always_ff @(posedge clk) begin
      xt_r    <= xt_full[RANK_W-1:0];
      xp_r    <= xp_full[RANK_W-1:0];
      sh_r    <= div_shift(ch_info[k].cnt[POS]);
      inv_r   <= div_inv(ch_info[k].cnt[POS]);
      tota_r  <= ch_tot[k];
      infoa_r <= ch_info[k];
    end

    // sub-step b: exact division by the count, accumulate the term
    assign mt_full = {{RANK_W{1'b0}}, xt_r >> sh_r} * {{RANK_W{1'b0}}, inv_r};
    assign mp_full = {{RANK_W{1'b0}}, xp_r >> sh_r} * {{RANK_W{1'b0}}, inv_r};
    assign term    = mt_full[RANK_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vb_r <= 1'b0;
      end else begin
        vb_r <= va_r;
      end
    end

    always_ff @(posedge clk) begin
      pb_r    <= mp_full[RANK_W-1:0];
      totb_r  <= tota_r + term;
      infob_r <= infoa_r;
    end

    assign ch_v[k+1]    = vb_r;
    assign ch_p[k+1]    = pb_r;
    assign ch_tot[k+1]  = totb_r;
    assign ch_info[k+1] = infob_r;
  end

  assign out_valid = ch_v[NUM_DIGITS];
  assign out_rank  = ch_tot[NUM_DIGITS];

  // every result comes from an earlier transaction
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching transaction");

  // every transaction yields its result
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("transaction lost in pipeline");

  // rank stays below the number of orderings of eight digits
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rank < 16'd40320)
    else $error("rank out of range");

  // the last position has no later digits and occurs once in its suffix
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (info1_r.sm[NUM_DIGITS-1] == '0 && info1_r.cnt[NUM_DIGITS-1] == CNT_W'(1)))
    else $error("bad counts at last position");

endmodule
